// ===== design/dq_pkg.sv =====
// Shared constants, codes and control/status types for the double-ended queue unit.
`default_nettype none
package dq_pkg;

  localparam int DEPTH = 64;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [2:0] CMD_POP_BACK   = 3'd3;
  localparam logic [2:0] CMD_DUMP_FWD   = 3'd4;
  localparam logic [2:0] CMD_DUMP_BWD   = 3'd5;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       dump_start;
    logic       dump_back;
    logic       rd_en;
    logic       load_status;
    logic [1:0] status_code;
    logic       load_item;
    logic       item_last;
  } dq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic out_free;
    logic rd_done;
    logic rd_last;
  } dq_stat_t;

endpackage
`default_nettype wire

// ===== design/dq_datapath.sv =====
// Datapath of the double-ended queue: element memory, indices, read sequencer and output register.
`default_nettype none
module dq_datapath import dq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dq_cmd_t            ctl,
  input  wire logic signed [31:0] value,
  input  wire logic               out_stall,
  output dq_stat_t                st,
  output logic                    out_valid,
  output logic signed [31:0]      item_value,
  output logic [1:0]              status,
  output logic                    last,
  output logic [CNT_W-1:0]        fill
);

  logic [31:0]      mem [DEPTH];
  logic [31:0]      rdata;
  logic [IDX_W-1:0] front_index;
  logic [IDX_W-1:0] front_index_next;
  logic [CNT_W-1:0] fill_count;
  logic [CNT_W-1:0] fill_count_next;
  logic [CNT_W-1:0] rd_idx;
  logic             dump_back;
  logic             item_pending;

  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  logic [IDX_W-1:0] front_dec;
  logic [IDX_W-1:0] front_inc;
  logic [CNT_W-1:0] rd_off;

  // Index of the slot at a given offset from the front, both below DEPTH.
  function automatic logic [IDX_W-1:0] slot_at(input logic [IDX_W-1:0] base,
                                               input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  always_comb begin
    front_dec = (front_index == '0) ? IDX_W'(DEPTH - 1) : front_index - IDX_W'(1);
    front_inc = (front_index == IDX_W'(DEPTH - 1)) ? '0 : front_index + IDX_W'(1);
    wr_addr   = ctl.push_front ? front_dec : slot_at(front_index, fill_count);
    rd_off    = dump_back ? (fill_count - CNT_W'(1) - rd_idx) : rd_idx;
    rd_addr   = slot_at(front_index, rd_off);
  end

  always_comb begin
    front_index_next = front_index;
    fill_count_next  = fill_count;
    if (ctl.push_front) begin
      front_index_next = front_dec;
      fill_count_next  = fill_count + CNT_W'(1);
    end else if (ctl.push_back) begin
      fill_count_next  = fill_count + CNT_W'(1);
    end else if (ctl.pop_front) begin
      front_index_next = front_inc;
      fill_count_next  = fill_count - CNT_W'(1);
    end else if (ctl.pop_back) begin
      fill_count_next  = fill_count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_index <= '0;
      fill_count  <= '0;
    end else begin
      front_index <= front_index_next;
      fill_count  <= fill_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_front || ctl.push_back) begin
      mem[wr_addr] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx    <= '0;
      dump_back <= 1'b0;
    end else if (ctl.dump_start) begin
      rd_idx    <= '0;
      dump_back <= ctl.dump_back;
    end else if (ctl.rd_en) begin
      rd_idx    <= rd_idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.load_status || ctl.load_item) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_status) begin
      item_value <= '0;
      status     <= ctl.status_code;
      last       <= 1'b1;
      fill       <= fill_count_next;
    end else if (ctl.load_item) begin
      item_value <= rdata;
      status     <= STATUS_OK;
      last       <= ctl.item_last;
      fill       <= fill_count;
    end
  end

  always_comb begin
    st.empty    = (fill_count == '0);
    st.full     = (fill_count >= CNT_W'(DEPTH));
    st.out_free = !out_valid || !out_stall;
    st.rd_done  = (rd_idx == fill_count);
    st.rd_last  = (rd_idx == fill_count - CNT_W'(1));
  end

  assign item_pending = ctl.load_status || ctl.load_item;

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(DEPTH))
    else $error("fill count above depth");
  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front_index <= IDX_W'(DEPTH - 1))
    else $error("front index out of range");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    item_pending |-> (!out_valid || !out_stall))
    else $error("output register loaded while holding a stalled transaction");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    (ctl.push_front || ctl.push_back) |-> !st.full)
    else $error("push onto a full store");
  a_no_overread: assert property (@(posedge clk) disable iff (rst)
    ctl.rd_en |-> !st.rd_done)
    else $error("dump read beyond the stored count");
`endif

endmodule
`default_nettype wire

// ===== design/dq_ctrl.sv =====
// Controller state machine of the double-ended queue: command decode and dump sequencing.
`default_nettype none
module dq_ctrl import dq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [2:0] cmd,
  input  wire dq_stat_t   st,
  output logic            in_stall,
  output dq_cmd_t         ctl
);

  state_t state;
  state_t state_next;
  logic   pend;
  logic   pend_next;
  logic   pend_last;
  logic   pend_last_next;
  logic   accept;
  logic   move;
  logic   issue;

  always_comb begin
    accept = (state == ST_IDLE) && in_valid && st.out_free;
    move   = (state == ST_DUMP) && pend && st.out_free;
    issue  = (state == ST_DUMP) && !st.rd_done && (!pend || move);
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (cmd inside {CMD_DUMP_FWD, CMD_DUMP_BWD}) && !st.empty) begin
          state_next = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (move && pend_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl            = '0;
    ctl.status_code = STATUS_OK;
    in_stall       = 1'b1;
    pend_next      = pend;
    pend_last_next = pend_last;
    case (state)
      ST_IDLE: begin
        in_stall = !st.out_free;
        if (accept) begin
          ctl.load_status = 1'b1;
          case (cmd)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              if (st.full) begin
                ctl.status_code = STATUS_FULL;
              end else begin
                ctl.push_front = (cmd == CMD_PUSH_FRONT);
                ctl.push_back  = (cmd == CMD_PUSH_BACK);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (st.empty) begin
                ctl.status_code = STATUS_EMPTY;
              end else begin
                ctl.pop_front = (cmd == CMD_POP_FRONT);
                ctl.pop_back  = (cmd == CMD_POP_BACK);
              end
            end
            CMD_DUMP_FWD, CMD_DUMP_BWD: begin
              if (st.empty) begin
                ctl.status_code = STATUS_EMPTY;
              end else begin
                ctl.load_status = 1'b0;
                ctl.dump_start  = 1'b1;
                ctl.dump_back   = (cmd == CMD_DUMP_BWD);
              end
            end
            default: ctl.status_code = STATUS_OK;
          endcase
        end
      end
      ST_DUMP: begin
        ctl.load_item = move;
        ctl.item_last = pend_last;
        ctl.rd_en     = issue;
        if (issue) begin
          pend_next      = 1'b1;
          pend_last_next = st.rd_last;
        end else if (move) begin
          pend_next      = 1'b0;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pend      <= 1'b0;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      pend_last <= pend_last_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pend)
    else $error("element left pending after a dump");
  a_dump_stalls: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> in_stall)
    else $error("input open during a dump");
  a_last_exit: assert property (@(posedge clk) disable iff (rst)
    (ctl.load_item && ctl.item_last) |=> (state == ST_IDLE))
    else $error("dump did not end on its last element");
`endif

endmodule
`default_nettype wire

// ===== design/double_ended_queue_unit.sv =====
// Top level of the double-ended queue unit: joins the controller and the datapath.
`default_nettype none
// A bounded double-ended queue of up to 64 signed 32-bit values kept in a circular
// memory with a front index and a fill count. Each input transaction carries a command:
// push front or back, pop front or back, dump front-to-back or back-to-front. Pushes,
// pops and unknown commands give one result transaction with item_value zero, a status
// (ok, empty, or full with the push dropped), last set, and the fill after the command.
// A dump gives one result per stored element, last set on the final one, or a single
// empty status when nothing is stored. Timing: a push, pop or unknown command is
// accepted whenever the output register is free or being drained, so such commands
// stream at one per cycle. A dump keeps in_stall high until its last element is loaded
// into the output register: each element is first read through the memory's registered
// read port, and elements then leave at one per cycle while out_stall is
// low. The output register lets a new command be taken while the previous result still
// waits, as long as that result leaves in the same cycle. The memory needs no clearing
// after reset, since only entries holding queued elements are ever read.
module double_ended_queue_unit import dq_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [2:0]         cmd,
  input  wire logic signed [31:0] value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      item_value,
  output logic [1:0]              status,
  output logic                    last,
  output logic [CNT_W-1:0]        fill
);

  // Commands flow from the controller, status returns from the datapath.
  dq_cmd_t  ctl;
  dq_stat_t st;

  dq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .cmd      (cmd),
    .st       (st),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  dq_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .value      (value),
    .out_stall  (out_stall),
    .st         (st),
    .out_valid  (out_valid),
    .item_value (item_value),
    .status     (status),
    .last       (last),
    .fill       (fill)
  );

endmodule
`default_nettype wire
